/* src/ptvc_pkg.sv */
// ---------------------------------------------------------------------------
// ptvc_pkg: shared types and codes of the post-transform vertex cache
// Operation codes, result status codes and the control bundle that the
// sequencer broadcasts to every cell of the line chain.
// ---------------------------------------------------------------------------
package ptvc_pkg;

    localparam logic [2:0] OP_LOOKUP  = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_CONFIRM = 3'd2;
    localparam logic [2:0] OP_CANCEL  = 3'd3;
    localparam logic [2:0] OP_START   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic clear;        // start: back to the reset contents
        logic pop;          // free queue moves up one slot
        logic alloc;        // selected line takes the query tags
        logic release_line; // selected line invalid and pending
        logic cancel;       // selected pending line valid again
        logic confirm_clr;  // selected line loses its pending mark
        logic append;       // tail slot takes the key line
        logic scan_tag;     // token compares tags, else free-queue slots
        logic shift;        // free scan closes the gap behind a match
    } ctrl_t;

endpackage

/* src/ptvc_cell.sv */
// ---------------------------------------------------------------------------
// ptvc_cell: one cell of the vertex cache chain
// Holds the tags and flags of one line and one slot of the free queue, and
// passes the scan token with its carry to the next cell.
// ---------------------------------------------------------------------------
module ptvc_cell #(
    parameter int LW  = 5,
    parameter int IDX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ptvc_pkg::ctrl_t  ctrl,
    input  logic             sel_line,
    input  logic             sel_tail,
    input  logic [31:0]      vertex_index,
    input  logic [31:0]      instance_id,
    input  logic [LW-1:0]    key,
    input  logic [LW:0]      count,
    input  logic [LW-1:0]    next_slot,
    output logic [LW-1:0]    slot,
    output logic             pending,
    input  logic             tok_in,
    input  logic             found_in,
    input  logic [LW-1:0]    idx_in,
    output logic             tok_out,
    output logic             found_out,
    output logic [LW-1:0]    idx_out
);

    logic [31:0]   tag_v_reg;
    logic [31:0]   tag_i_reg;
    logic          valid_reg;
    logic          pend_reg;
    logic [LW-1:0] slot_reg;
    logic          tok_reg;
    logic          found_reg;
    logic [LW-1:0] idx_reg;
    logic          hit_here;
    logic          found_now;

    always_comb
    begin
        if (ctrl.scan_tag)
        begin
            hit_here = valid_reg && (tag_v_reg == vertex_index) && (tag_i_reg == instance_id);
        end
        else
        begin
            hit_here = ((LW+1)'(IDX) < count) && (slot_reg == key);
        end
        found_now = found_in | hit_here;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_v_reg <= '0;
            tag_i_reg <= '0;
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
            slot_reg  <= LW'(IDX);
            tok_reg   <= 1'b0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            tok_reg   <= tok_in;
            found_reg <= found_now;
            idx_reg   <= found_in ? idx_in : LW'(IDX);
            if (ctrl.clear)
            begin
                tag_v_reg <= '0;
                tag_i_reg <= '0;
                valid_reg <= 1'b0;
                pend_reg  <= 1'b0;
                slot_reg  <= LW'(IDX);
            end
            else
            begin
                if (ctrl.alloc && sel_line)
                begin
                    tag_v_reg <= vertex_index;
                    tag_i_reg <= instance_id;
                    valid_reg <= 1'b1;
                end
                else if (ctrl.release_line && sel_line)
                begin
                    valid_reg <= 1'b0;
                end
                else if (ctrl.cancel && sel_line && pend_reg)
                begin
                    valid_reg <= 1'b1;
                end
                if (ctrl.release_line && sel_line)
                begin
                    pend_reg <= 1'b1;
                end
                else if ((ctrl.cancel || ctrl.confirm_clr) && sel_line)
                begin
                    pend_reg <= 1'b0;
                end
                // The shift wave runs one cell per cycle, so the neighbor
                // still holds its old slot when this cell copies it.
                if (ctrl.pop || (tok_in && ctrl.shift && found_now))
                begin
                    slot_reg <= next_slot;
                end
                else if (ctrl.append && sel_tail)
                begin
                    slot_reg <= key;
                end
            end
        end
    end

    assign slot      = slot_reg;
    assign pending   = pend_reg;
    assign tok_out   = tok_reg;
    assign found_out = found_reg;
    assign idx_out   = idx_reg;

endmodule

/* src/post_transform_vertex_cache.sv */
// ---------------------------------------------------------------------------
// post_transform_vertex_cache: fully associative post-transform vertex cache
// Lines tagged by vertex index and instance, with a free queue of lines,
// built as a chain of cells that a scan token walks one cell per cycle.
// ---------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         tuser operation, tdata vertex_index/instance_id/line_number
//  m_axis    out        tdata hit/line_out/status
//
// Lookup hit: the tag scan, then the free-queue scan that removes the line, then
// the result is handed out. Lookup miss: the tag scan, then the result. Confirm
// of a pending line: the free-queue scan, then the result. Release, cancel,
// start, confirm of a line not pending and other codes answer in the cycle after
// acceptance. The token walking the chain of line cells paces the scans.
// Reset restores the reset contents at once; a stalled result holds new beats off.
// ---------------------------------------------------------------------------
module post_transform_vertex_cache #(
    parameter int LINES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // vertex_index, instance_id, line_number, pad
    input  logic [2:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // hit, line_out, status
);

    localparam int LW = $clog2(LINES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TAG  = 2'd1;
    localparam logic [1:0] S_FREE = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic            launch_reg, launch_next;
    logic [2:0]      op_reg, op_next;
    logic [31:0]     vtx_reg, vtx_next;
    logic [31:0]     ins_reg, ins_next;
    logic [LW-1:0]   key_reg, key_next;
    logic [LW:0]     count_reg, count_next;
    logic [7:0]      res_reg, res_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_data_reg, out_data_next;

    ptvc_pkg::ctrl_t ctrl;
    logic [LINES-1:0]  pend_vec;
    logic [LW-1:0]     slot_vec  [LINES];
    logic [LINES:0]    tok_c;
    logic [LINES:0]    found_c;
    logic [LW-1:0]     idx_c     [LINES+1];

    logic        accept;
    logic        out_free;
    logic [2:0]  in_op;
    logic [31:0] in_vtx;
    logic [31:0] in_ins;
    logic [4:0]  in_ln;
    logic        ln_ok;
    logic [LW-1:0] q0;

    assign in_op  = s_axis_tuser;
    assign in_vtx = s_axis_tdata[31:0];
    assign in_ins = s_axis_tdata[63:32];
    assign in_ln  = s_axis_tdata[68:64];
    assign ln_ok  = 32'(in_ln) < LINES;
    assign q0     = slot_vec[0];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign tok_c[0]   = launch_reg;
    assign found_c[0] = 1'b0;
    assign idx_c[0]   = '0;

    genvar k;
    generate
        for (k = 0; k < LINES; k++)
        begin : g_cell
            logic          sel_line;
            logic          sel_tail;
            logic [LW-1:0] next_slot;

            assign sel_line  = ctrl.alloc ? (q0 == LW'(k)) : (32'(in_ln) == 32'(k));
            assign sel_tail  = count_reg == (LW+1)'(k);
            if (k == LINES - 1)
            begin : g_last
                assign next_slot = slot_vec[k];
            end
            else
            begin : g_mid
                assign next_slot = slot_vec[k+1];
            end

            ptvc_cell #(
                .LW  (LW),
                .IDX (k)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .sel_line     (sel_line),
                .sel_tail     (sel_tail),
                .vertex_index (vtx_reg),
                .instance_id  (ins_reg),
                .key          (key_reg),
                .count        (count_reg),
                .next_slot    (next_slot),
                .slot         (slot_vec[k]),
                .pending      (pend_vec[k]),
                .tok_in       (tok_c[k]),
                .found_in     (found_c[k]),
                .idx_in       (idx_c[k]),
                .tok_out      (tok_c[k+1]),
                .found_out    (found_c[k+1]),
                .idx_out      (idx_c[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        launch_next    = 1'b0;
        op_next        = op_reg;
        vtx_next       = vtx_reg;
        ins_next       = ins_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        ctrl           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = in_op;
                    vtx_next = in_vtx;
                    ins_next = in_ins;
                    // Operations that need no scan answer right away.
                    out_valid_next = 1'b1;
                    out_data_next  = {ptvc_pkg::ST_OK, in_ln, 1'b0};
                    case (in_op)
                        ptvc_pkg::OP_LOOKUP:
                        begin
                            out_valid_next = 1'b0;
                            launch_next    = 1'b1;
                            state_next     = S_TAG;
                        end
                        ptvc_pkg::OP_RELEASE:
                        begin
                            ctrl.release_line = ln_ok;
                        end
                        ptvc_pkg::OP_CONFIRM:
                        begin
                            if (ln_ok && pend_vec[LW'(in_ln)])
                            begin
                                ctrl.confirm_clr = 1'b1;
                                key_next       = LW'(in_ln);
                                res_next       = {ptvc_pkg::ST_OK, in_ln, 1'b0};
                                out_valid_next = 1'b0;
                                launch_next    = 1'b1;
                                state_next     = S_FREE;
                            end
                        end
                        ptvc_pkg::OP_CANCEL:
                        begin
                            ctrl.cancel = ln_ok;
                        end
                        ptvc_pkg::OP_START:
                        begin
                            ctrl.clear    = 1'b1;
                            count_next    = (LW+1)'(LINES);
                            out_data_next = '0;
                        end
                        default:
                        begin
                            out_data_next = '0;
                        end
                    endcase
                end
            end
            S_TAG:
            begin
                ctrl.scan_tag = 1'b1;
                if (tok_c[LINES])
                begin
                    if (found_c[LINES])
                    begin
                        key_next    = idx_c[LINES];
                        res_next    = {ptvc_pkg::ST_OK, 5'(idx_c[LINES]), 1'b1};
                        launch_next = 1'b1;
                        state_next  = S_FREE;
                    end
                    else if (count_reg == '0)
                    begin
                        res_next   = {ptvc_pkg::ST_NO_FREE, 5'd0, 1'b0};
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ctrl.pop   = 1'b1;
                        ctrl.alloc = 1'b1;
                        count_next = count_reg - 1'b1;
                        res_next   = {ptvc_pkg::ST_OK, 5'(q0), 1'b0};
                        state_next = S_FIN;
                    end
                end
            end
            S_FREE:
            begin
                ctrl.shift = (op_reg == ptvc_pkg::OP_LOOKUP);
                if (tok_c[LINES])
                begin
                    state_next = S_FIN;
                    if (op_reg == ptvc_pkg::OP_LOOKUP)
                    begin
                        if (found_c[LINES])
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else if (!found_c[LINES])
                    begin
                        if (count_reg >= (LW+1)'(LINES))
                        begin
                            res_next[7:6] = ptvc_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.append = 1'b1;
                            count_next  = count_reg + 1'b1;
                        end
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            count_reg     <= (LW+1)'(LINES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        vtx_reg      <= vtx_next;
        ins_reg      <= ins_next;
        key_reg      <= key_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (LW+1)'(LINES))
        else $error("free count above line count");
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("beat accepted while a lookup is in flight");
    a_start_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser == ptvc_pkg::OP_START) |=> count_reg == (LW+1)'(LINES))
        else $error("start did not refill the free queue");
`endif

endmodule
